### src/ladbtn_pkg.sv
// Shared types, constants and register map of the ladder button press classifier.
package ladbtn_pkg;

	localparam int SAMPLE_BITS_DEF = 10;
	localparam int TIMER_BITS_DEF  = 16;

	localparam int HOLD_W  = 16;
	localparam int LEVEL_W = 10;
	localparam int EVENT_W = 3;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 32;

	localparam logic [HOLD_W-1:0]  HOLD_RESET   = 16'd1000;
	localparam logic [LEVEL_W-1:0] PRESS_RESET  = 10'd1000;
	localparam logic [LEVEL_W-1:0] WIN_LO_RESET = 10'd70;
	localparam logic [LEVEL_W-1:0] WIN_HI_RESET = 10'd110;

	localparam logic [1:0] REG_HOLD     = 2'd0;
	localparam logic [1:0] REG_PRESS    = 2'd1;
	localparam logic [1:0] REG_WIN_LOW  = 2'd2;
	localparam logic [1:0] REG_WIN_HIGH = 2'd3;

	localparam logic [EVENT_W-1:0] EV_B1_SHORT = 3'd1;
	localparam logic [EVENT_W-1:0] EV_B2_SHORT = 3'd2;
	localparam logic [EVENT_W-1:0] EV_B1_LONG  = 3'd3;
	localparam logic [EVENT_W-1:0] EV_B2_LONG  = 3'd4;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_TIMING = 2'd1,
		PH_WAIT   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [HOLD_W-1:0]  hold_ticks;
		logic [LEVEL_W-1:0] press_level;
		logic [LEVEL_W-1:0] window_low;
		logic [LEVEL_W-1:0] window_high;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic [EVENT_W-1:0]  code;
	} evt_t;

endpackage

### src/ladbtn_regs.sv
// APB register file holding the classifier thresholds.
module ladbtn_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ladbtn_pkg::ADDR_W-1:0]   paddr,
	input  logic [ladbtn_pkg::DATA_W-1:0]   pwdata,
	output logic [ladbtn_pkg::DATA_W-1:0]   prdata,
	output logic                            pready,
	output ladbtn_pkg::cfg_t                cfg
);

	ladbtn_pkg::cfg_t cfg_q;
	logic [1:0]       idx;
	logic             wr_en;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hold_ticks  <= ladbtn_pkg::HOLD_RESET;
			cfg_q.press_level <= ladbtn_pkg::PRESS_RESET;
			cfg_q.window_low  <= ladbtn_pkg::WIN_LO_RESET;
			cfg_q.window_high <= ladbtn_pkg::WIN_HI_RESET;
		end else if (wr_en) begin
			case (idx)
				ladbtn_pkg::REG_HOLD: begin
					cfg_q.hold_ticks <= pwdata[ladbtn_pkg::HOLD_W-1:0];
				end
				ladbtn_pkg::REG_PRESS: begin
					cfg_q.press_level <= pwdata[ladbtn_pkg::LEVEL_W-1:0];
				end
				ladbtn_pkg::REG_WIN_LOW: begin
					cfg_q.window_low <= pwdata[ladbtn_pkg::LEVEL_W-1:0];
				end
				ladbtn_pkg::REG_WIN_HIGH: begin
					cfg_q.window_high <= pwdata[ladbtn_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			ladbtn_pkg::REG_HOLD:     prdata = ladbtn_pkg::DATA_W'(cfg_q.hold_ticks);
			ladbtn_pkg::REG_PRESS:    prdata = ladbtn_pkg::DATA_W'(cfg_q.press_level);
			ladbtn_pkg::REG_WIN_LOW:  prdata = ladbtn_pkg::DATA_W'(cfg_q.window_low);
			ladbtn_pkg::REG_WIN_HIGH: prdata = ladbtn_pkg::DATA_W'(cfg_q.window_high);
			default:                  prdata = '0;
		endcase
	end

endmodule

### src/ladbtn_ctrl.sv
// Press timing state machine that classifies short and long presses.
module ladbtn_ctrl #(
	parameter int SAMPLE_BITS = ladbtn_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = ladbtn_pkg::TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] sample,
	input  logic                   tick,
	input  ladbtn_pkg::cfg_t       cfg,
	output ladbtn_pkg::evt_t       evt
);

	localparam int LW = (SAMPLE_BITS > ladbtn_pkg::LEVEL_W) ? SAMPLE_BITS : ladbtn_pkg::LEVEL_W;
	localparam int CW = (TIMER_BITS > ladbtn_pkg::HOLD_W) ? TIMER_BITS : ladbtn_pkg::HOLD_W;

	ladbtn_pkg::phase_t     phase_q, phase_d;
	logic [SAMPLE_BITS-1:0] captured_q, captured_d;
	logic [TIMER_BITS-1:0]  elapsed_q, elapsed_d;
	logic [TIMER_BITS-1:0]  elapsed_inc;
	logic                   released, pressed, long_hit;
	logic                   is_b1, is_b2;
	logic [LW-1:0]          s_ext, cap_ext, press_ext, wlo_ext, whi_ext;

	assign s_ext     = LW'(sample);
	assign cap_ext   = LW'(captured_q);
	assign press_ext = LW'(cfg.press_level);
	assign wlo_ext   = LW'(cfg.window_low);
	assign whi_ext   = LW'(cfg.window_high);

	assign released    = s_ext > press_ext;
	assign pressed     = s_ext < press_ext;
	assign elapsed_inc = (elapsed_q == {TIMER_BITS{1'b1}}) ? elapsed_q : elapsed_q + 1'b1;
	assign long_hit    = CW'(elapsed_inc) >= CW'(cfg.hold_ticks);
	assign is_b1       = captured_q == '0;
	assign is_b2       = (cap_ext >= wlo_ext) && (cap_ext <= whi_ext);

	always_comb begin
		phase_d    = phase_q;
		captured_d = captured_q;
		elapsed_d  = elapsed_q;
		case (phase_q)
			ladbtn_pkg::PH_TIMING: begin
				if (released) begin
					phase_d = ladbtn_pkg::PH_IDLE;
				end else if (tick) begin
					elapsed_d = elapsed_inc;
					if (long_hit) begin
						phase_d = ladbtn_pkg::PH_WAIT;
					end
				end
			end
			ladbtn_pkg::PH_WAIT: begin
				if (released) begin
					phase_d = ladbtn_pkg::PH_IDLE;
				end
			end
			default: begin
				phase_d = ladbtn_pkg::PH_IDLE;
				if (pressed) begin
					captured_d = sample;
					elapsed_d  = '0;
					phase_d    = ladbtn_pkg::PH_TIMING;
				end
			end
		endcase
	end

	always_comb begin
		evt.valid = 1'b0;
		evt.code  = ladbtn_pkg::EV_B1_SHORT;
		case (phase_q)
			ladbtn_pkg::PH_TIMING: begin
				if (released) begin
					evt.valid = is_b1 || is_b2;
					evt.code  = is_b1 ? ladbtn_pkg::EV_B1_SHORT : ladbtn_pkg::EV_B2_SHORT;
				end else if (tick && long_hit) begin
					evt.valid = is_b1 || is_b2;
					evt.code  = is_b1 ? ladbtn_pkg::EV_B1_LONG : ladbtn_pkg::EV_B2_LONG;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= ladbtn_pkg::PH_IDLE;
			captured_q <= '0;
			elapsed_q  <= '0;
		end else if (step) begin
			phase_q    <= phase_d;
			captured_q <= captured_d;
			elapsed_q  <= elapsed_d;
		end
	end

endmodule

### src/adc_ladder_button_press_classifier_unit.sv
// Timing: an item is registered in the input register on acceptance, and its result is registered
// in the output register when the item advances out of the input register, and is offered from there.
// Throughput: one item per cycle while results are taken; a stalled result holds the next
// item in the input register, and the input stalls once that register is full.
// Reset: arst_n clears phase, captured level, tick count and valid flags at once,
// and loads the thresholds with their default values.
module adc_ladder_button_press_classifier_unit #(
	parameter int SAMPLE_BITS = ladbtn_pkg::SAMPLE_BITS_DEF,
	parameter int TIMER_BITS  = ladbtn_pkg::TIMER_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [SAMPLE_BITS-1:0]              sample,
	input  logic                                tick,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [ladbtn_pkg::EVENT_W-1:0]      event_code,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ladbtn_pkg::ADDR_W-1:0]       paddr,
	input  logic [ladbtn_pkg::DATA_W-1:0]       pwdata,
	output logic [ladbtn_pkg::DATA_W-1:0]       prdata,
	output logic                                pready
);

	ladbtn_pkg::cfg_t                 cfg;
	ladbtn_pkg::evt_t                 evt;
	logic                             valid_s1;
	logic [SAMPLE_BITS-1:0]           sample_s1;
	logic                             tick_s1;
	logic                             out_valid_q;
	logic [ladbtn_pkg::EVENT_W-1:0]   event_code_q;
	logic                             advance;

	assign advance    = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || advance;
	assign out_valid  = out_valid_q;
	assign event_code = event_code_q;

	ladbtn_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ladbtn_ctrl #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIMER_BITS  (TIMER_BITS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.sample (sample_s1),
		.tick   (tick_s1),
		.cfg    (cfg),
		.evt    (evt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
			tick_s1   <= tick;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= evt.valid;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_code_q <= evt.code;
		end
	end

endmodule

### src/ladbtn_checker.sv
// Port-level checks of the classifier, bound to the top level.
module ladbtn_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ladbtn_pkg::EVENT_W-1:0]  event_code
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_code))
		else $error("A stalled result item changed or vanished.");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_code == ladbtn_pkg::EV_B1_SHORT ||
			event_code == ladbtn_pkg::EV_B2_SHORT ||
			event_code == ladbtn_pkg::EV_B1_LONG ||
			event_code == ladbtn_pkg::EV_B2_LONG))
		else $error("Result item carries an undefined event code.");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("Input stalled although no result item is pending.");

endmodule

bind adc_ladder_button_press_classifier_unit ladbtn_checker u_ladbtn_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (in_ready),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.event_code (event_code)
);

### verif/adc_ladder_button_press_classifier_unit_tb.sv
// Self-checking testbench of the ladder button press classifier: directed and random presses.
module adc_ladder_button_press_classifier_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ladbtn_pkg::*;

	localparam int SAMPLE_W = SAMPLE_BITS_DEF;
	localparam int TIMER_W = TIMER_BITS_DEF;
	localparam int LIMIT = 1000000;
	localparam int SETTLE = 4;

	typedef enum int {NO_BUTTON, BUTTON_ONE, BUTTON_TWO} button_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [SAMPLE_W-1:0] sample;
	logic tick;
	logic out_valid;
	logic out_ready;
	logic [EVENT_W-1:0] event_code;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;

	adc_ladder_button_press_classifier_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.tick(tick),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_code(event_code),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	cfg_t knobs;
	phase_t press_phase;
	logic [LEVEL_W-1:0] held_level;
	logic [TIMER_W-1:0] tick_count;

	logic [EVENT_W-1:0] pending_events[$];
	int mismatches = 0;
	int items_sent = 0;
	int events_seen = 0;
	int reg_writes = 0;
	int event_tally[5];
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	int hold_off_left = 0;
	int cycle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("Timeout after %0d cycles with %0d events outstanding", cycle_count,
				pending_events.size());
			$display("FAIL adc_ladder_button_press_classifier_unit");
			$finish;
		end
	end

	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_left > 0) begin
				out_ready <= 1'b0;
				hold_off_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin
		logic [EVENT_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			events_seen++;
			if (event_code >= 1 && event_code <= 4)
				event_tally[event_code]++;
			if (pending_events.size() == 0) begin
				report_mismatch($sformatf("event %0d with none expected", event_code));
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want)
					report_mismatch($sformatf("event_code %0d, expected %0d", event_code, want));
			end
		end
	end

	function automatic void reset_predictor();
		knobs.hold_ticks = HOLD_RESET;
		knobs.press_level = PRESS_RESET;
		knobs.window_low = WIN_LO_RESET;
		knobs.window_high = WIN_HI_RESET;
		press_phase = PH_IDLE;
		held_level = '0;
		tick_count = '0;
	endfunction

	function automatic bit classify_sample(input logic [SAMPLE_W-1:0] s, input logic t,
			output logic [EVENT_W-1:0] code);
		button_t button;
		bit hit;
		hit = 1'b0;
		code = '0;
		if (held_level == '0)
			button = BUTTON_ONE;
		else if (held_level >= knobs.window_low && held_level <= knobs.window_high)
			button = BUTTON_TWO;
		else
			button = NO_BUTTON;
		case (press_phase)
			PH_TIMING: begin
				if (s > knobs.press_level) begin
					press_phase = PH_IDLE;
					hit = (button != NO_BUTTON);
					code = (button == BUTTON_ONE) ? EV_B1_SHORT : EV_B2_SHORT;
				end else if (t) begin
					if (tick_count != '1)
						tick_count++;
					if (tick_count >= knobs.hold_ticks) begin
						press_phase = PH_WAIT;
						hit = (button != NO_BUTTON);
						code = (button == BUTTON_ONE) ? EV_B1_LONG : EV_B2_LONG;
					end
				end
			end
			PH_WAIT: begin
				if (s > knobs.press_level)
					press_phase = PH_IDLE;
			end
			default: begin
				press_phase = PH_IDLE;
				if (s < knobs.press_level) begin
					held_level = s;
					tick_count = '0;
					press_phase = PH_TIMING;
				end
			end
		endcase
		return hit;
	endfunction

	task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic t);
		logic [EVENT_W-1:0] code;
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		tick <= t;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
		if (classify_sample(s, t, code))
			pending_events.push_back(code);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [DATA_W-1:0] reg_value(input logic [1:0] idx);
		case (idx)
			REG_HOLD: return DATA_W'(knobs.hold_ticks);
			REG_PRESS: return DATA_W'(knobs.press_level);
			REG_WIN_LOW: return DATA_W'(knobs.window_low);
			default: return DATA_W'(knobs.window_high);
		endcase
	endfunction

	task automatic read_reg(input logic [1:0] idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== reg_value(idx))
			report_mismatch($sformatf("register %0d reads %0h, expected %0h", idx, prdata,
				reg_value(idx)));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_HOLD: knobs.hold_ticks = value[HOLD_W-1:0];
			REG_PRESS: knobs.press_level = value[LEVEL_W-1:0];
			REG_WIN_LOW: knobs.window_low = value[LEVEL_W-1:0];
			default: knobs.window_high = value[LEVEL_W-1:0];
		endcase
		reg_writes++;
		@(posedge clk);
		read_reg(idx);
	endtask

	task automatic set_thresholds(input int hold, input int level, input int lo, input int hi);
		drain_results();
		write_reg(REG_HOLD, hold);
		write_reg(REG_PRESS, level);
		write_reg(REG_WIN_LOW, lo);
		write_reg(REG_WIN_HIGH, hi);
	endtask

	function automatic logic [SAMPLE_W-1:0] release_level();
		if (knobs.press_level == '1)
			return '1;
		return SAMPLE_W'($urandom_range(int'(knobs.press_level) + 1, 1023));
	endfunction

	task automatic press_sequence();
		int lim;
		int top;
		logic [SAMPLE_W-1:0] lvl;
		lim = knobs.press_level;
		if ($urandom_range(9) == 0) begin
			offer_sample(SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
			return;
		end
		repeat ($urandom_range(2)) offer_sample(release_level(), 1'($urandom_range(1)));
		if (lim == 0) begin
			offer_sample(SAMPLE_W'($urandom_range(1023)), 1'($urandom_range(1)));
			return;
		end
		top = (knobs.window_high < lim) ? knobs.window_high : lim - 1;
		case ($urandom_range(3))
			0: lvl = '0;
			1, 2: begin
				if (knobs.window_low <= top)
					lvl = SAMPLE_W'($urandom_range(top, knobs.window_low));
				else
					lvl = SAMPLE_W'($urandom_range(lim - 1));
			end
			default: lvl = SAMPLE_W'($urandom_range(lim - 1));
		endcase
		offer_sample(lvl, 1'($urandom_range(1)));
		repeat ($urandom_range(int'(knobs.hold_ticks) + 3))
			offer_sample(SAMPLE_W'($urandom_range(lim)), $urandom_range(99) < 60);
		if ($urandom_range(4) != 0)
			offer_sample(release_level(), 1'($urandom_range(1)));
	endtask

	task automatic test_reset_defaults();
		for (int i = 0; i < 4; i++)
			read_reg(i[1:0]);
		offer_sample(10'd1023, 1'b1);
		offer_sample(10'd0, 1'b1);
		offer_sample(10'd1023, 1'b0);
		offer_sample(10'd91, 1'b0);
		offer_sample(10'd1023, 1'b0);
		drain_results();
	endtask

	task automatic test_short_and_long_presses();
		set_thresholds(32'hABCD_0002, 1000, 70, 110);
		offer_sample(10'd0, 1'b1);
		offer_sample(10'd0, 1'b1);
		offer_sample(10'd1001, 1'b1);
		offer_sample(10'd110, 1'b0);
		offer_sample(10'd1000, 1'b0);
		offer_sample(10'd1023, 1'b1);
		offer_sample(10'd0, 1'b0);
		offer_sample(10'd1000, 1'b1);
		offer_sample(10'd12, 1'b1);
		offer_sample(10'd500, 1'b1);
		offer_sample(10'd1000, 1'b0);
		offer_sample(10'd1001, 1'b0);
		offer_sample(10'd70, 1'b1);
		offer_sample(10'd70, 1'b1);
		offer_sample(10'd999, 1'b1);
		offer_sample(10'd1023, 1'b0);
		offer_sample(10'd69, 1'b0);
		offer_sample(10'd1023, 1'b0);
		offer_sample(10'd111, 1'b0);
		offer_sample(10'd1023, 1'b0);
		offer_sample(10'd1000, 1'b0);
		offer_sample(10'd1023, 1'b0);
		drain_results();
	endtask

	task automatic test_edge_settings();
		set_thresholds(32'hFFFF_0000, 1000, 0, 1023);
		offer_sample(10'd0, 1'b0);
		offer_sample(10'd0, 1'b1);
		offer_sample(10'd1023, 1'b0);
		offer_sample(10'd500, 1'b1);
		offer_sample(10'd1001, 1'b1);
		drain_results();
		write_reg(REG_PRESS, 0);
		offer_sample(10'd0, 1'b1);
		offer_sample(10'd1023, 1'b1);
		drain_results();
		write_reg(REG_PRESS, 1023);
		offer_sample(10'd1022, 1'b1);
		offer_sample(10'd1023, 1'b1);
		offer_sample(10'd1023, 1'b0);
		drain_results();
		write_reg(REG_PRESS, 1000);
		offer_sample(10'd1001, 1'b0);
		drain_results();
	endtask

	task automatic test_random_presses(input int count, input int hold, input int level,
			input int lo, input int hi);
		int start;
		set_thresholds(hold, level, lo, hi);
		start = items_sent;
		while (items_sent - start < count)
			press_sequence();
		drain_results();
	endtask

	task automatic test_counter_limit();
		set_thresholds(48, 1000, 70, 110);
		offer_sample(10'd1023, 1'b1);
		offer_sample(10'd0, 1'b1);
		repeat (60) offer_sample(SAMPLE_W'($urandom_range(1000)), 1'b1);
		offer_sample(10'd1023, 1'b1);
		drain_results();
	endtask

	task automatic test_output_stall();
		set_thresholds(1, 1000, 70, 110);
		hold_off_left = 150;
		repeat (40) begin
			offer_sample(10'd0, 1'b0);
			offer_sample(10'd0, 1'b1);
			offer_sample(10'd1023, 1'b0);
		end
		drain_results();
		hold_off_left = 60;
		repeat (20) begin
			offer_sample(10'd91, 1'b0);
			offer_sample(10'd1023, 1'b1);
		end
		drain_results();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		sample <= '0;
		tick <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		reset_predictor();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_gap_pct = 15;
		recv_gap_pct = 60;
		test_reset_defaults();
		test_short_and_long_presses();
		test_edge_settings();
		test_random_presses(200, $urandom_range(8, 1), $urandom_range(1023, 600), 70, 110);

		send_gap_pct = 60;
		recv_gap_pct = 15;
		test_random_presses(200, $urandom_range(20, 1), $urandom_range(1023, 1),
			$urandom_range(1023), $urandom_range(1023));

		send_gap_pct = 0;
		recv_gap_pct = 0;
		test_random_presses(190, 3, 1022, 0, 1023);
		test_counter_limit();
		test_output_stall();

		drain_results();
		$display("Sent %0d items under %0d register writes; checked %0d events", items_sent,
			reg_writes, events_seen);
		$display("Short presses %0d/%0d, long presses %0d/%0d (button 1/button 2)",
			event_tally[1], event_tally[2], event_tally[3], event_tally[4]);
		if (mismatches == 0) begin
			$display("PASS adc_ladder_button_press_classifier_unit");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAIL adc_ladder_button_press_classifier_unit");
		end
		$finish;
	end

endmodule

### filelist.f
src/ladbtn_pkg.sv
src/ladbtn_regs.sv
src/ladbtn_ctrl.sv
src/adc_ladder_button_press_classifier_unit.sv
src/ladbtn_checker.sv
verif/adc_ladder_button_press_classifier_unit_tb.sv
